// ===== hw/rtl/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Throughput stall detector package
// Shared types, widths, action codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

  // Default buffer size in bytes used for the stall threshold
  localparam int BUFFER_BYTES_DEF = 262144;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int BYTES_W = 32;
  localparam int RATE_W  = 32;
  localparam int MS_W    = 32;
  localparam int TOTAL_W = 48;
  localparam int MULT_W  = 8;
  localparam int MINS_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Shared divider widths: bytes*1000 needs 42 bits
  localparam int DVD_W = 42;
  localparam int DVS_W = 32;

  // Actions
  localparam logic [ACT_W-1:0] ACT_START    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PROGRESS = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEC  = 2'd2;

  // Register reset values
  localparam logic [RATE_W-1:0] MIN_RATE_RST = 32'd1024;
  localparam logic [MULT_W-1:0] MULT_RST     = 8'd48;
  localparam logic [MINS_W-1:0] MIN_SEC_RST  = 16'd5;

  // Command item
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BYTES_W-1:0] bytes_reported;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic               stalled;
    logic [RATE_W-1:0]  smoothed_rate;
    logic [TOTAL_W-1:0] bytes_total;
  } res_t;

  // Threshold compare flags
  typedef struct packed {
    logic rate_over;
    logic time_over;
  } flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/throughput_stall_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Throughput stall detector
// Adaptive watchdog: smoothed transfer rate and a rate-scaled stall timeout.
// ----------------------------------------------------------------------------
//  Channel  | Signals                     | Dir | Notes
//  ---------+-----------------------------+-----+------------------------------
//  cmd      | cmd_valid, cmd_stall, cmd   | in  | action and byte count
//  res      | res_valid, res_stall, res   | out | stall flag, rate, byte total
//  cfg      | cfg_we, cfg_index, cfg_data | in  | min rate, multiplier, min sec
//
//  Start, stop, tick and ignored reports go straight to the multiply and
//  output steps. A report with elapsed time first runs the shared serial
//  divider for the instant rate and, when a smoothed rate already exists,
//  the divide by ten as two reciprocal multiply steps. One item is in work
//  at a time. Reset is synchronous; a finished result waits in the output
//  register while res_stall is high and the next item can be taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module throughput_stall_detector_unit #(
  parameter int BUFFER_BYTES = tsd_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output logic                                cmd_stall,
  input  wire tsd_pkg::cmd_t                  cmd,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output tsd_pkg::res_t                       res,
  input  wire logic                           cfg_we,
  input  wire logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_RATE = 3'd1;
  localparam logic [2:0] S_TEN_HI   = 3'd2;
  localparam logic [2:0] S_TEN_LO   = 3'd3;
  localparam logic [2:0] S_MUL      = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  localparam int RATE_W  = tsd_pkg::RATE_W;
  localparam int MS_W    = tsd_pkg::MS_W;
  localparam int TOTAL_W = tsd_pkg::TOTAL_W;
  localparam int DVD_W   = tsd_pkg::DVD_W;
  localparam int DVS_W   = tsd_pkg::DVS_W;

  // Divide by ten in two 18-bit digits; floor(y/10) = (y*TEN_RCP) >> 25 for y < 2^22
  localparam int AVG_W  = 36;
  localparam int HALF_W = 18;
  localparam int TEN_W  = 22;
  localparam int TEN_SH = 25;
  localparam int TEN_QW = 2*TEN_W - TEN_SH;
  localparam logic [TEN_W-1:0] TEN_RCP = 22'd3355444;

  // Configuration
  logic [RATE_W-1:0]          minimum_rate;
  logic [tsd_pkg::MULT_W-1:0] multiplier_sixteenths;
  logic [tsd_pkg::MINS_W-1:0] min_wait_sec;

  // State
  logic [2:0]         state, state_next;
  logic               running, running_next;
  logic [RATE_W-1:0]  rate_average, rate_average_next;
  logic [MS_W-1:0]    ms_since_progress, ms_since_progress_next;
  logic [TOTAL_W-1:0] byte_sum, byte_sum_next;
  logic               res_load;

  // Divide-by-ten step registers
  logic [AVG_W-1:0]   avg_num, avg_num_next;
  logic [HALF_W-1:0]  ten_quo, ten_quo_next;
  logic [3:0]         ten_rem, ten_rem_next;
  logic [TEN_W-1:0]   ten_in;
  logic [2*TEN_W-1:0] ten_prod;
  logic [TEN_QW-1:0]  ten_q;
  logic [TEN_W-1:0]   ten_r;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quotient;

  logic             accept;
  logic [TOTAL_W:0] sum_wide;
  logic [RATE_W-1:0] instant;
  logic [RATE_W-1:0] eff_rate;
  tsd_pkg::flags_t   flags;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;

  // Shared serial divider
  tsd_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Threshold compare
  assign eff_rate = (rate_average > minimum_rate) ? rate_average : minimum_rate;

  tsd_thresh #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_thresh (
    .clk      (clk),
    .load     (state == S_MUL),
    .ms       (ms_since_progress),
    .eff_rate (eff_rate),
    .mult     (multiplier_sixteenths),
    .min_sec  (min_wait_sec),
    .flags    (flags)
  );

  // Instant rate saturates to 32 bits
  assign instant = (div_quotient[DVD_W-1:RATE_W] != '0) ? '1 : div_quotient[RATE_W-1:0];

  // Saturating byte total
  assign sum_wide = {1'b0, byte_sum} + (TOTAL_W+1)'(cmd.bytes_reported);

  // One digit of the divide by ten: high half first, then remainder and low half
  always_comb begin
    ten_in   = (state == S_TEN_LO) ? {ten_rem, avg_num[HALF_W-1:0]}
                                   : {4'd0, avg_num[AVG_W-1:HALF_W]};
    ten_prod = (2*TEN_W)'(ten_in) * (2*TEN_W)'(TEN_RCP);
    ten_q    = ten_prod[2*TEN_W-1:TEN_SH];
    ten_r    = ten_in - TEN_W'(ten_q) * TEN_W'(10);
  end

  // Sequencer
  always_comb begin
    state_next             = state;
    running_next           = running;
    rate_average_next      = rate_average;
    ms_since_progress_next = ms_since_progress;
    byte_sum_next          = byte_sum;
    avg_num_next           = avg_num;
    ten_quo_next           = ten_quo;
    ten_rem_next           = ten_rem;
    div_start              = 1'b0;
    div_dividend           = DVD_W'(cmd.bytes_reported) * DVD_W'(1000);
    div_divisor            = ms_since_progress;
    res_load               = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
          case (cmd.action)
            tsd_pkg::ACT_START, tsd_pkg::ACT_STOP: begin
              running_next           = (cmd.action == tsd_pkg::ACT_START);
              rate_average_next      = '0;
              ms_since_progress_next = '0;
              byte_sum_next          = '0;
            end
            tsd_pkg::ACT_PROGRESS: begin
              if (running) begin
                byte_sum_next          = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                ms_since_progress_next = '0;
                if (ms_since_progress != '0) begin
                  div_start  = 1'b1;
                  state_next = S_DIV_RATE;
                end
              end
            end
            tsd_pkg::ACT_TICK: begin
              if (running && (ms_since_progress != '1)) begin
                ms_since_progress_next = ms_since_progress + MS_W'(1);
              end
            end
            default: begin
              state_next = S_MUL;
            end
          endcase
        end
      end
      S_DIV_RATE: begin
        // Instant rate ready: take it, or fold it in with 7/10 and 3/10
        if (div_done) begin
          if (rate_average == '0) begin
            rate_average_next = instant;
            state_next        = S_MUL;
          end else begin
            avg_num_next = AVG_W'(rate_average) * AVG_W'(7) + AVG_W'(instant) * AVG_W'(3);
            state_next   = S_TEN_HI;
          end
        end
      end
      S_TEN_HI: begin
        ten_quo_next = ten_q[HALF_W-1:0];
        ten_rem_next = ten_r[3:0];
        state_next   = S_TEN_LO;
      end
      S_TEN_LO: begin
        // Quotient fits 32 bits since the sum is at most ten times a 32-bit value
        rate_average_next = {ten_quo[RATE_W-HALF_W-1:0], ten_q[HALF_W-1:0]};
        state_next        = S_MUL;
      end
      S_MUL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      running           <= 1'b0;
      rate_average      <= '0;
      ms_since_progress <= '0;
      byte_sum          <= '0;
      avg_num           <= '0;
      ten_quo           <= '0;
      ten_rem           <= '0;
      res_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      running           <= running_next;
      rate_average      <= rate_average_next;
      ms_since_progress <= ms_since_progress_next;
      byte_sum          <= byte_sum_next;
      avg_num           <= avg_num_next;
      ten_quo           <= ten_quo_next;
      ten_rem           <= ten_rem_next;
      res_valid         <= res_load || (res_valid && res_stall);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.stalled       <= running && flags.rate_over && flags.time_over;
      res.smoothed_rate <= rate_average;
      res.bytes_total   <= byte_sum;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_rate          <= tsd_pkg::MIN_RATE_RST;
      multiplier_sixteenths <= tsd_pkg::MULT_RST;
      min_wait_sec          <= tsd_pkg::MIN_SEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsd_pkg::CFG_MIN_RATE: minimum_rate          <= cfg_data[RATE_W-1:0];
        tsd_pkg::CFG_MULT:     multiplier_sixteenths <= cfg_data[tsd_pkg::MULT_W-1:0];
        tsd_pkg::CFG_MIN_SEC:  min_wait_sec          <= cfg_data[tsd_pkg::MINS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_no_div_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_done)
    else $error("divider finished outside a divide step");

  a_stopped_clear: assert property (@(posedge clk) disable iff (rst)
    !running |-> ((rate_average == '0) && (ms_since_progress == '0) && (byte_sum == '0)))
    else $error("progress state not clear while stopped");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_OUT))
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

// ===== hw/rtl/tsd_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_div #(
  parameter int DVD_W = tsd_pkg::DVD_W,
  parameter int DVS_W = tsd_pkg::DVS_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;

  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W:0]   diff;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    ge      = (shifted >= {1'b0, dvs});
    diff    = shifted - {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== hw/rtl/tsd_thresh.sv =====
// ----------------------------------------------------------------------------
// Stall threshold unit
// Registers elapsed*rate and the limits, then compares in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_thresh #(
  parameter int BUFFER_BYTES = tsd_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [tsd_pkg::MS_W-1:0]    ms,
  input  wire logic [tsd_pkg::RATE_W-1:0]  eff_rate,
  input  wire logic [tsd_pkg::MULT_W-1:0]  mult,
  input  wire logic [tsd_pkg::MINS_W-1:0]  min_sec,
  output tsd_pkg::flags_t                  flags
);

  localparam int PROD_W = tsd_pkg::MS_W + tsd_pkg::RATE_W;
  localparam logic [63:0] SCALE = 64'(BUFFER_BYTES) * 64'd1000;
  localparam int SCALE_W = $clog2(SCALE + 64'd1);
  localparam int LIM_W   = SCALE_W + tsd_pkg::MULT_W;
  localparam int MINMS_W = tsd_pkg::MINS_W + 10;

  logic [PROD_W-1:0]  prod;
  logic [LIM_W-1:0]   limit_full;
  logic [LIM_W-5:0]   limit;
  logic               time_over;
  logic [MINMS_W-1:0] min_ms;
  logic [LIM_W-1:0]   limit_calc;

  // Buffer*1000*mult, divided by 16 below
  always_comb begin
    limit_calc = {{tsd_pkg::MULT_W{1'b0}}, SCALE[SCALE_W-1:0]}
               * {{SCALE_W{1'b0}}, mult};
    min_ms     = MINMS_W'(min_sec) * MINMS_W'(1000);
  end

  // Stage register: product and limits
  always_ff @(posedge clk) begin
    if (load) begin
      prod       <= PROD_W'(ms) * PROD_W'(eff_rate);
      limit_full <= limit_calc;
      time_over  <= (ms > tsd_pkg::MS_W'(min_ms));
    end
  end

  assign limit = limit_full[LIM_W-1:4];

  // Compare against the rate based limit
  always_comb begin
    flags.rate_over = (prod > PROD_W'(limit));
    flags.time_over = time_over;
  end

endmodule

`default_nettype wire
